### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ordered unique set.
// Bodies are empty when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

### hw/rtl/ouis_pkg.sv
// Package for the ordered unique set: field widths, request and status codes.
// No dependencies.
package ouis_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned OUT_W    = 8;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

### hw/rtl/ouis_store.sv
// Entry memory of the ordered unique set with registered read and key compare.
// Depends on ouis_pkg.
module ouis_store import ouis_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  input  logic [VALUE_W-1:0] key_i,
  output logic [VALUE_W-1:0] rdata_o,
  output logic               match_o
);

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign match_o = (rdata_q == key_i);

endmodule

### hw/rtl/ordered_unique_int_set.sv
// Top level of the ordered unique set: handshake, sequencer and result register.
// Depends on ouis_pkg, ouis_store and assert_macros.svh.
//
// channel   dir  tdata                                tuser
// s_axis    in   [31:0] value                         [0] req_type
// m_axis    out  [2:0] status, [7:3] count            -
//
// A request scans the stored entries in order, up to CAPACITY of them, through one
// memory read port and one comparator; a remove then shifts each later entry down
// by one. Reset empties the set at once. s_axis_tready_o is low while a request is
// in work, and a finished result waits in the output register until m_axis_tready_i
// is high.
`include "assert_macros.svh"
module ordered_unique_int_set import ouis_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [VALUE_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic               s_axis_tuser_i,  // [0] req_type
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OUT_W-1:0]   m_axis_tdata_o   // [2:0] status, [7:3] count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = CW + COUNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       count_q, count_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_data_q, out_data_d;
  logic                kind_q;
  logic [VALUE_W-1:0]  key_q;

  logic                accept;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [VALUE_W-1:0]  wdata, rdata;
  logic                match;
  logic [CW:0]         idx_inc, idx_inc2, count_ext;
  logic [EW-1:0]       cnt_wide;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign idx_inc         = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_inc2        = {1'b0, idx_q} + (CW+1)'(2);
  assign count_ext       = {1'b0, count_q};
  assign cnt_wide        = EW'(count_q);

  ouis_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .key_i   (key_q),
    .rdata_o (rdata),
    .match_o (match)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    we          = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = rdata;
    raddr       = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          idx_d = '0;
          if (count_q == '0) begin
            state_d = S_FINISH;
            if (s_axis_tuser_i == REQ_ADD) begin
              we       = 1'b1;
              waddr    = '0;
              wdata    = s_axis_tdata_i;
              count_d  = CW'(1);
              status_d = ST_ADDED;
            end else begin
              status_d = ST_NOTFOUND;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match) begin
          if (kind_q == REQ_ADD) begin
            status_d = ST_PRESENT;
            state_d  = S_FINISH;
          end else if (idx_inc < count_ext) begin
            raddr   = idx_inc[AW-1:0];
            state_d = S_SHIFT;
          end else begin
            count_d  = count_q - CW'(1);
            status_d = ST_REMOVED;
            state_d  = S_FINISH;
          end
        end else if (idx_inc < count_ext) begin
          raddr = idx_inc[AW-1:0];
          idx_d = idx_inc[CW-1:0];
        end else begin
          state_d = S_FINISH;
          if (kind_q == REQ_REMOVE) begin
            status_d = ST_NOTFOUND;
          end else if (count_ext >= (CW+1)'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            we       = 1'b1;
            waddr    = count_q[AW-1:0];
            wdata    = key_q;
            count_d  = count_q + CW'(1);
            status_d = ST_ADDED;
          end
        end
      end
      S_SHIFT: begin
        we = 1'b1;
        if (idx_inc2 < count_ext) begin
          raddr = idx_inc2[AW-1:0];
          idx_d = idx_inc[CW-1:0];
        end else begin
          count_d  = count_q - CW'(1);
          status_d = ST_REMOVED;
          state_d  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {cnt_wide[COUNT_W-1:0], status_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      status_q    <= ST_ADDED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser_i;
      key_q  <= s_axis_tdata_i;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_ext <= (CW+1)'(CAPACITY), "count above capacity")
  `ASSERT_CLK(a_shift_range, clk_i, rst_ni, (state_q == S_SHIFT) |-> (idx_inc < count_ext), "shift past end")
  `ASSERT_CLK(a_busy_after_beat, clk_i, rst_ni, accept |=> !s_axis_tready_o, "ready right after beat")
  `ASSERT_CLK(a_count_change, clk_i, rst_ni, (count_q != $past(count_q)) |-> ($past(state_q) != S_FINISH), "count moved while finishing")

endmodule
